// ----- hw/rtl/pes_pkg.sv -----
// Shared widths, types, register codes and reset values for the particle Euler step.
`default_nettype none

package pes_pkg;

	localparam int NUM_AXES = 3;
	localparam int POS_W    = 32;
	localparam int VAL_W    = 16;
	localparam int LIM_W    = 15;

	// Intermediate widths of the velocity datapath.
	localparam int PROD_W  = 33;  // 16x17 signed product
	localparam int DTERM_W = 18;  // product >>> 15
	localparam int ATERM_W = 21;  // product >>> 12
	localparam int SUM_W   = 22;  // drag term + accel term

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;

	typedef logic signed [POS_W-1:0] pos_t;
	typedef logic signed [VAL_W-1:0] val_t;
	typedef logic signed [SUM_W-1:0] sum_t;
	typedef logic [CFG_IDX_W-1:0]    cfg_idx_t;

	// Register indexes on the configuration port.
	localparam cfg_idx_t REG_MAX_SPEEDS  = 3'd0;
	localparam cfg_idx_t REG_KEEP        = 3'd1;
	localparam cfg_idx_t REG_GRAVITY     = 3'd2;
	localparam cfg_idx_t REG_FRAME       = 3'd3;
	localparam cfg_idx_t REG_PAUSED      = 3'd4;

	localparam logic [3*LIM_W-1:0] RST_MAX_SPEEDS = '1;
	localparam logic [3*VAL_W-1:0] RST_KEEP       = 48'h8000_8000_8000;
	localparam logic [3*VAL_W-1:0] RST_GRAVITY    = '0;
	localparam logic [VAL_W-1:0]   RST_FRAME      = 16'd4096;

	localparam pos_t POS_MAX = 32'sh7FFF_FFFF;
	localparam pos_t POS_MIN = 32'sh8000_0000;
	localparam sum_t VEL_MIN = -22'sd32768;

endpackage

`default_nettype wire

// ----- hw/rtl/particle_euler_step.sv -----
// Particle Euler step top: input, output registers; one object per clock unless stalled.
`default_nettype none

// One explicit Euler frame per object. Each transaction on the input channel carries
// position (Q24.8), velocity and acceleration (Q8.8) on three axes; each produces exactly
// one output transaction. New position = position + velocity, saturated to 32 bits.
// New velocity = floor(vel * keep / 2^15) + floor(acc * frame / 2^12), clamped to
// +/- the axis limit (a limit of all ones only saturates to 16 bits). New acceleration
// is the configured gravity. With paused set, the object passes through unchanged.
// Throughput is one object per clock while the output is not stalled. The input
// register feeds the multiply, add and clamp logic, which loads the output register.
// Stall travels back combinationally through the two stage enables, so the input
// register keeps loading while the output register has room. Configuration registers
// reset to: no speed limits, keep factors 1.0, zero gravity, frame factor 1.0, not
// paused. cfg_ready is always high; indexes above four are dropped. Write configuration
// only while idle.
module particle_euler_step (
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          in_valid,
	output logic                          in_stall,
	input  pes_pkg::pos_t                 pos_x,
	input  pes_pkg::pos_t                 pos_y,
	input  pes_pkg::pos_t                 pos_z,
	input  pes_pkg::val_t                 vel_x,
	input  pes_pkg::val_t                 vel_y,
	input  pes_pkg::val_t                 vel_z,
	input  pes_pkg::val_t                 acc_x,
	input  pes_pkg::val_t                 acc_y,
	input  pes_pkg::val_t                 acc_z,

	output logic                          out_valid,
	input  logic                          out_stall,
	output pes_pkg::pos_t                 new_pos_x,
	output pes_pkg::pos_t                 new_pos_y,
	output pes_pkg::pos_t                 new_pos_z,
	output pes_pkg::val_t                 new_vel_x,
	output pes_pkg::val_t                 new_vel_y,
	output pes_pkg::val_t                 new_vel_z,
	output pes_pkg::val_t                 new_acc_x,
	output pes_pkg::val_t                 new_acc_y,
	output pes_pkg::val_t                 new_acc_z,

	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  pes_pkg::cfg_idx_t             cfg_index,
	input  logic [pes_pkg::CFG_DATA_W-1:0] cfg_data
);

	// ---------------------------------------------------------------- configuration
	logic [3*pes_pkg::LIM_W-1:0] max_speeds_q;
	logic [3*pes_pkg::VAL_W-1:0] keep_q;
	logic [3*pes_pkg::VAL_W-1:0] gravity_q;
	logic [pes_pkg::VAL_W-1:0]   frame_q;
	logic                        paused_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speeds_q <= pes_pkg::RST_MAX_SPEEDS;
			keep_q       <= pes_pkg::RST_KEEP;
			gravity_q    <= pes_pkg::RST_GRAVITY;
			frame_q      <= pes_pkg::RST_FRAME;
			paused_q     <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pes_pkg::REG_MAX_SPEEDS: max_speeds_q <= cfg_data[3*pes_pkg::LIM_W-1:0];
				pes_pkg::REG_KEEP:       keep_q       <= cfg_data;
				pes_pkg::REG_GRAVITY:    gravity_q    <= cfg_data;
				pes_pkg::REG_FRAME:      frame_q      <= cfg_data[pes_pkg::VAL_W-1:0];
				pes_pkg::REG_PAUSED:     paused_q     <= cfg_data[0];
				default: ;  // unknown index: write dropped
			endcase
		end
	end

	// ---------------------------------------------------------------- stage control
	logic valid_s1, out_valid_q;
	logic en_s1, en_out;

	// A stage loads when it is empty or its content moves on this cycle.
	assign en_out   = !out_valid_q || !out_stall;
	assign en_s1    = !valid_s1 || en_out;
	assign in_stall = !en_s1;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en_s1)  valid_s1    <= in_valid;
			if (en_out) out_valid_q <= valid_s1;
		end
	end

	// ---------------------------------------------------------------- stage 1: input register
	pes_pkg::pos_t pos_s1 [pes_pkg::NUM_AXES];
	pes_pkg::val_t vel_s1 [pes_pkg::NUM_AXES];
	pes_pkg::val_t acc_s1 [pes_pkg::NUM_AXES];

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			pos_s1[0] <= pos_x;
			pos_s1[1] <= pos_y;
			pos_s1[2] <= pos_z;
			vel_s1[0] <= vel_x;
			vel_s1[1] <= vel_y;
			vel_s1[2] <= vel_z;
			acc_s1[0] <= acc_x;
			acc_s1[1] <= acc_y;
			acc_s1[2] <= acc_z;
		end
	end

	// ---------------------------------------------------------------- multiply, add, clamp
	logic signed [pes_pkg::PROD_W-1:0]  dprod   [pes_pkg::NUM_AXES];
	logic signed [pes_pkg::PROD_W-1:0]  aprod   [pes_pkg::NUM_AXES];
	logic signed [pes_pkg::DTERM_W-1:0] dterm   [pes_pkg::NUM_AXES];
	logic signed [pes_pkg::ATERM_W-1:0] aterm   [pes_pkg::NUM_AXES];
	logic signed [pes_pkg::POS_W:0]     psum    [pes_pkg::NUM_AXES];
	pes_pkg::pos_t                      pos_nxt [pes_pkg::NUM_AXES];
	pes_pkg::val_t                      acc_nxt [pes_pkg::NUM_AXES];
	pes_pkg::sum_t                      vsum    [pes_pkg::NUM_AXES];
	pes_pkg::sum_t                      vhi     [pes_pkg::NUM_AXES];
	pes_pkg::sum_t                      vlo     [pes_pkg::NUM_AXES];
	logic [pes_pkg::LIM_W-1:0]          lim     [pes_pkg::NUM_AXES];
	pes_pkg::val_t                      vel_nxt [pes_pkg::NUM_AXES];

	always_comb begin
		for (int a = 0; a < pes_pkg::NUM_AXES; a++) begin
			// keep and frame are unsigned: zero-extend before the signed multiply
			dprod[a] = pes_pkg::PROD_W'(vel_s1[a])
				* $signed({17'd0, keep_q[a*pes_pkg::VAL_W +: pes_pkg::VAL_W]});
			aprod[a] = pes_pkg::PROD_W'(acc_s1[a]) * $signed({17'd0, frame_q});
			// floor division by a power of two is an arithmetic shift
			dterm[a] = dprod[a][pes_pkg::PROD_W-1:15];
			aterm[a] = aprod[a][pes_pkg::PROD_W-1:12];

			psum[a] = (pes_pkg::POS_W+1)'(pos_s1[a]) + (pes_pkg::POS_W+1)'(vel_s1[a]);
			if (psum[a][pes_pkg::POS_W] != psum[a][pes_pkg::POS_W-1])
				pos_nxt[a] = psum[a][pes_pkg::POS_W] ? pes_pkg::POS_MIN : pes_pkg::POS_MAX;
			else
				pos_nxt[a] = psum[a][pes_pkg::POS_W-1:0];
			if (paused_q)
				pos_nxt[a] = pos_s1[a];

			acc_nxt[a] = paused_q ? acc_s1[a]
				: pes_pkg::val_t'(gravity_q[a*pes_pkg::VAL_W +: pes_pkg::VAL_W]);

			vsum[a] = pes_pkg::SUM_W'(dterm[a]) + pes_pkg::SUM_W'(aterm[a]);
			lim[a]  = max_speeds_q[a*pes_pkg::LIM_W +: pes_pkg::LIM_W];
			vhi[a]  = $signed(pes_pkg::SUM_W'(lim[a]));
			// all-ones limit: plain 16-bit saturation (upper bound is already 32767)
			vlo[a]  = (&lim[a]) ? pes_pkg::VEL_MIN : -vhi[a];
			if (vsum[a] < vlo[a])
				vel_nxt[a] = vlo[a][pes_pkg::VAL_W-1:0];
			else if (vsum[a] > vhi[a])
				vel_nxt[a] = vhi[a][pes_pkg::VAL_W-1:0];
			else
				vel_nxt[a] = vsum[a][pes_pkg::VAL_W-1:0];
			if (paused_q)
				vel_nxt[a] = vel_s1[a];
		end
	end

	// ---------------------------------------------------------------- output register
	pes_pkg::pos_t pos_q [pes_pkg::NUM_AXES];
	pes_pkg::val_t vel_q [pes_pkg::NUM_AXES];
	pes_pkg::val_t acc_q [pes_pkg::NUM_AXES];

	always_ff @(posedge clk) begin
		if (en_out && valid_s1) begin
			for (int a = 0; a < pes_pkg::NUM_AXES; a++) begin
				pos_q[a] <= pos_nxt[a];
				vel_q[a] <= vel_nxt[a];
				acc_q[a] <= acc_nxt[a];
			end
		end
	end

	assign new_pos_x = pos_q[0];
	assign new_pos_y = pos_q[1];
	assign new_pos_z = pos_q[2];
	assign new_vel_x = vel_q[0];
	assign new_vel_y = vel_q[1];
	assign new_vel_z = vel_q[2];
	assign new_acc_x = acc_q[0];
	assign new_acc_y = acc_q[1];
	assign new_acc_z = acc_q[2];

endmodule

`default_nettype wire

// ----- hw/rtl/pes_checker.sv -----
// Port-level checks for the particle Euler step, bound to the top level.
`default_nettype none

module pes_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_stall,
	input logic          out_valid,
	input logic          out_stall,
	input logic          cfg_valid,
	input logic          cfg_ready,
	input pes_pkg::pos_t new_pos_x,
	input pes_pkg::pos_t new_pos_y,
	input pes_pkg::pos_t new_pos_z,
	input pes_pkg::val_t new_vel_x,
	input pes_pkg::val_t new_vel_y,
	input pes_pkg::val_t new_vel_z,
	input pes_pkg::val_t new_acc_x,
	input pes_pkg::val_t new_acc_y,
	input pes_pkg::val_t new_acc_z
);

	// a stalled output transaction stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output valid dropped under stall");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(new_pos_x) && $stable(new_pos_y)
			&& $stable(new_pos_z) && $stable(new_vel_x) && $stable(new_vel_y)
			&& $stable(new_vel_z) && $stable(new_acc_x) && $stable(new_acc_y)
			&& $stable(new_acc_z))
		else $error("output payload changed under stall");

	// input backs up only when the whole pipe is full behind a stalled output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a stalled output");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind particle_euler_step pes_checker u_pes_checker (.*);

`default_nettype wire

// ----- test/tb_particle_euler_step.sv -----
// Self-checking testbench for the particle Euler step: directed corners, then random traffic.
`timescale 1ns / 1ps

module tb_particle_euler_step;

	// A limit of all ones on an axis means no limit, only 16-bit saturation.
	localparam logic [pes_pkg::LIM_W-1:0] SPEED_UNLIMITED = '1;
	localparam pes_pkg::val_t             VAL_MAX         = 16'sh7FFF;
	localparam pes_pkg::val_t             VAL_MIN         = 16'sh8000;
	localparam logic [pes_pkg::VAL_W-1:0] KEEP_ONE        = 16'h8000;  // Q1.15 1.0
	localparam logic [pes_pkg::VAL_W-1:0] FRAME_ONE       = 16'd4096;  // Q4.12 1.0
	localparam int                        DRAIN_CYCLES    = 4;         // pipeline is two deep
	localparam int                        WATCHDOG_LIMIT  = 2000;
	localparam int                        RANDOM_PER_CFG  = 250;

	// One object; used for both the input and the result transaction.
	// Packed arrays are indexed by axis: 0 = x, 1 = y, 2 = z.
	typedef struct packed {
		pes_pkg::pos_t [pes_pkg::NUM_AXES-1:0] pos;
		pes_pkg::val_t [pes_pkg::NUM_AXES-1:0] vel;
		pes_pkg::val_t [pes_pkg::NUM_AXES-1:0] acc;
	} body_t;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           in_valid  = 1'b0;
	logic                           in_stall;
	pes_pkg::pos_t                  pos_x     = '0;
	pes_pkg::pos_t                  pos_y     = '0;
	pes_pkg::pos_t                  pos_z     = '0;
	pes_pkg::val_t                  vel_x     = '0;
	pes_pkg::val_t                  vel_y     = '0;
	pes_pkg::val_t                  vel_z     = '0;
	pes_pkg::val_t                  acc_x     = '0;
	pes_pkg::val_t                  acc_y     = '0;
	pes_pkg::val_t                  acc_z     = '0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	pes_pkg::pos_t                  new_pos_x, new_pos_y, new_pos_z;
	pes_pkg::val_t                  new_vel_x, new_vel_y, new_vel_z;
	pes_pkg::val_t                  new_acc_x, new_acc_y, new_acc_z;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	pes_pkg::cfg_idx_t              cfg_index = '0;
	logic [pes_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

	// Shadow copy of the register file, updated on each accepted write.
	logic [3*pes_pkg::LIM_W-1:0] limit_cfg   = pes_pkg::RST_MAX_SPEEDS;
	logic [3*pes_pkg::VAL_W-1:0] keep_cfg    = pes_pkg::RST_KEEP;
	logic [3*pes_pkg::VAL_W-1:0] gravity_cfg = pes_pkg::RST_GRAVITY;
	logic [pes_pkg::VAL_W-1:0]   frame_cfg   = pes_pkg::RST_FRAME;
	logic                        paused_cfg  = 1'b0;

	body_t frames_due [$];   // predicted results, oldest first
	int    fail_count     = 0;
	int    idle_cycles    = 0;
	int    send_idle_pct  = 0;
	int    recv_stall_pct = 0;

	particle_euler_step u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pos_z     (pos_z),
		.vel_x     (vel_x),
		.vel_y     (vel_y),
		.vel_z     (vel_z),
		.acc_x     (acc_x),
		.acc_y     (acc_y),
		.acc_z     (acc_z),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.new_pos_x (new_pos_x),
		.new_pos_y (new_pos_y),
		.new_pos_z (new_pos_z),
		.new_vel_x (new_vel_x),
		.new_vel_y (new_vel_y),
		.new_vel_z (new_vel_z),
		.new_acc_x (new_acc_x),
		.new_acc_y (new_acc_y),
		.new_acc_z (new_acc_z),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Receiver back-pressure, changed only on the falling edge.
	always @(negedge clk) begin
		out_stall = ($urandom_range(99) < recv_stall_pct);
	end

	// One Euler frame under the shadow configuration.
	function automatic body_t euler_frame(body_t obj);
		body_t         nxt;
		pes_pkg::pos_t p;
		pes_pkg::val_t v, a;
		longint        np, nv, lim, lo, hi;
		if (paused_cfg)
			return obj;
		for (int ax = 0; ax < pes_pkg::NUM_AXES; ax++) begin
			p = obj.pos[ax];
			v = obj.vel[ax];
			a = obj.acc[ax];
			np = longint'(p) + longint'(v);
			if (np > longint'(pes_pkg::POS_MAX))
				np = pes_pkg::POS_MAX;
			else if (np < longint'(pes_pkg::POS_MIN))
				np = pes_pkg::POS_MIN;
			// >>> on a signed longint floors, matching the block's arithmetic shift
			nv = ((longint'(v) * longint'(keep_cfg[ax*pes_pkg::VAL_W +: pes_pkg::VAL_W])) >>> 15)
			   + ((longint'(a) * longint'(frame_cfg)) >>> 12);
			lim = longint'(limit_cfg[ax*pes_pkg::LIM_W +: pes_pkg::LIM_W]);
			if (limit_cfg[ax*pes_pkg::LIM_W +: pes_pkg::LIM_W] == SPEED_UNLIMITED) begin
				lo = -32768;
				hi = 32767;
			end else begin
				lo = -lim;
				hi = lim;
			end
			if (nv < lo)
				nv = lo;
			else if (nv > hi)
				nv = hi;
			nxt.pos[ax] = pes_pkg::pos_t'(np);
			nxt.vel[ax] = pes_pkg::val_t'(nv);
			nxt.acc[ax] = gravity_cfg[ax*pes_pkg::VAL_W +: pes_pkg::VAL_W];
		end
		return nxt;
	endfunction

	task automatic report_mismatch(string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		fail_count++;
	endtask

	// Result checking, plus a watchdog on cycles where no transaction happens anywhere.
	always @(posedge clk) begin : check_results
		body_t got, want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got.pos = {new_pos_z, new_pos_y, new_pos_x};
				got.vel = {new_vel_z, new_vel_y, new_vel_x};
				got.acc = {new_acc_z, new_acc_y, new_acc_x};
				if (frames_due.size() == 0) begin
					report_mismatch("result transaction with no frame pending");
				end else begin
					want = frames_due.pop_front();
					for (int ax = 0; ax < pes_pkg::NUM_AXES; ax++) begin
						if (got.pos[ax] !== want.pos[ax])
							report_mismatch($sformatf("new_pos axis %0d: got %0d want %0d",
								ax, $signed(got.pos[ax]), $signed(want.pos[ax])));
						if (got.vel[ax] !== want.vel[ax])
							report_mismatch($sformatf("new_vel axis %0d: got %0d want %0d",
								ax, $signed(got.vel[ax]), $signed(want.vel[ax])));
						if (got.acc[ax] !== want.acc[ax])
							report_mismatch($sformatf("new_acc axis %0d: got %0d want %0d",
								ax, $signed(got.acc[ax]), $signed(want.acc[ax])));
					end
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("[%0t] watchdog: no transaction for %0d cycles", $realtime, idle_cycles);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// Register write; called on a falling edge, returns on a falling edge.
	task automatic write_reg(pes_pkg::cfg_idx_t idx, logic [pes_pkg::CFG_DATA_W-1:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			pes_pkg::REG_MAX_SPEEDS: limit_cfg   = data[3*pes_pkg::LIM_W-1:0];
			pes_pkg::REG_KEEP:       keep_cfg    = data[3*pes_pkg::VAL_W-1:0];
			pes_pkg::REG_GRAVITY:    gravity_cfg = data[3*pes_pkg::VAL_W-1:0];
			pes_pkg::REG_FRAME:      frame_cfg   = data[pes_pkg::VAL_W-1:0];
			pes_pkg::REG_PAUSED:     paused_cfg  = data[0];
			default:                 ;  // unused index, dropped by the block
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// One input transaction with optional idle cycles first. Valid stays high
	// on return so back-to-back objects go out without a gap.
	task automatic send_body(body_t obj);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		{pos_z, pos_y, pos_x} = obj.pos;
		{vel_z, vel_y, vel_x} = obj.vel;
		{acc_z, acc_y, acc_x} = obj.acc;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		frames_due.push_back(euler_frame(obj));
		@(negedge clk);
	endtask

	// Stop sending and wait until every pending frame has come out.
	task automatic wait_idle();
		in_valid = 1'b0;
		while (frames_due.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic body_t rand_body();
		body_t obj;
		for (int ax = 0; ax < pes_pkg::NUM_AXES; ax++) begin
			case ($urandom_range(3))
				0:       obj.pos[ax] = pes_pkg::POS_MAX - pes_pkg::pos_t'($urandom_range(40000));
				1:       obj.pos[ax] = pes_pkg::POS_MIN + pes_pkg::pos_t'($urandom_range(40000));
				default: obj.pos[ax] = $urandom;
			endcase
			case ($urandom_range(7))
				0:       obj.vel[ax] = VAL_MAX;
				1:       obj.vel[ax] = VAL_MIN;
				default: obj.vel[ax] = pes_pkg::val_t'($urandom);
			endcase
			case ($urandom_range(7))
				0:       obj.acc[ax] = VAL_MAX;
				1:       obj.acc[ax] = VAL_MIN;
				default: obj.acc[ax] = pes_pkg::val_t'($urandom);
			endcase
		end
		return obj;
	endfunction

	// Random register settings, weighted toward the extremes.
	task automatic rand_config();
		logic [3*pes_pkg::LIM_W-1:0] lims;
		logic [3*pes_pkg::VAL_W-1:0] keeps;
		logic [pes_pkg::VAL_W-1:0]   frame;
		for (int ax = 0; ax < pes_pkg::NUM_AXES; ax++) begin
			case ($urandom_range(3))
				0:       lims[ax*pes_pkg::LIM_W +: pes_pkg::LIM_W] = '0;
				1:       lims[ax*pes_pkg::LIM_W +: pes_pkg::LIM_W] = SPEED_UNLIMITED;
				2:       lims[ax*pes_pkg::LIM_W +: pes_pkg::LIM_W] =
						pes_pkg::LIM_W'($urandom_range(255));
				default: lims[ax*pes_pkg::LIM_W +: pes_pkg::LIM_W] =
						pes_pkg::LIM_W'($urandom_range(32766));
			endcase
			case ($urandom_range(3))
				0:       keeps[ax*pes_pkg::VAL_W +: pes_pkg::VAL_W] = '0;
				1:       keeps[ax*pes_pkg::VAL_W +: pes_pkg::VAL_W] = KEEP_ONE;
				2:       keeps[ax*pes_pkg::VAL_W +: pes_pkg::VAL_W] = '1;
				default: keeps[ax*pes_pkg::VAL_W +: pes_pkg::VAL_W] = pes_pkg::VAL_W'($urandom);
			endcase
		end
		case ($urandom_range(3))
			0:       frame = '0;
			1:       frame = FRAME_ONE;
			2:       frame = '1;
			default: frame = pes_pkg::VAL_W'($urandom);
		endcase
		// upper data bits beyond the speed-limit, frame and paused widths are random and must be ignored
		write_reg(pes_pkg::REG_MAX_SPEEDS, {3'($urandom_range(7)), lims});
		write_reg(pes_pkg::REG_KEEP, keeps);
		write_reg(pes_pkg::REG_GRAVITY, {$urandom, 16'($urandom)});
		write_reg(pes_pkg::REG_FRAME, {$urandom, frame});
		write_reg(pes_pkg::REG_PAUSED, {$urandom, 15'($urandom), ($urandom_range(7) == 0)});
	endtask

	// Default registers after reset: unlimited speeds, no drag, no gravity.
	task automatic test_reset_values();
		body_t obj;
		obj = '0;
		send_body(obj);
		// position overflow upward, velocity saturating at the top of 16 bits
		obj.pos = {pes_pkg::POS_MAX, pes_pkg::POS_MAX, pes_pkg::POS_MAX};
		obj.vel = {16'sd1, VAL_MAX, 16'sd256};
		obj.acc = {VAL_MAX, VAL_MAX, -16'sd1};
		send_body(obj);
		// position overflow downward, velocity saturating at the bottom
		obj.pos = {pes_pkg::POS_MIN, pes_pkg::POS_MIN, pes_pkg::POS_MIN + 32'sd5};
		obj.vel = {VAL_MIN, -16'sd1, -16'sd6};
		obj.acc = {VAL_MIN, VAL_MIN, 16'sd3};
		send_body(obj);
		wait_idle();
	endtask

	// Finite limits per axis, keep factor above 1.0, largest frame factor.
	task automatic test_velocity_clamp();
		body_t obj;
		write_reg(pes_pkg::REG_MAX_SPEEDS, {3'b0, 15'd32766, 15'd1000, 15'd0});
		write_reg(pes_pkg::REG_KEEP, {16'h8000, 16'h0000, 16'hFFFF});
		write_reg(pes_pkg::REG_GRAVITY, {16'hFFFF, 16'h8000, 16'h7FFF});
		write_reg(pes_pkg::REG_FRAME, 48'h0000_0000_FFFF);
		obj.pos = {32'sd0, 32'sd100, -32'sd100};
		obj.vel = {VAL_MAX, VAL_MAX, VAL_MAX};
		obj.acc = {VAL_MAX, VAL_MAX, VAL_MAX};
		send_body(obj);
		obj.vel = {VAL_MIN, VAL_MIN, VAL_MIN};
		obj.acc = {VAL_MIN, VAL_MIN, VAL_MIN};
		send_body(obj);
		obj.vel = {-16'sd1, 16'sd1, -16'sd1};
		obj.acc = {16'sd1, -16'sd1, 16'sd0};
		send_body(obj);
		obj.vel = {16'sd500, -16'sd500, 16'sd0};
		obj.acc = {-16'sd16, 16'sd16, 16'sd0};
		send_body(obj);
		wait_idle();
	endtask

	// Zero keep and frame factors wipe out velocity; floor of small negatives.
	task automatic test_zero_factors();
		body_t obj;
		write_reg(pes_pkg::REG_MAX_SPEEDS, '1);
		write_reg(pes_pkg::REG_KEEP, '0);
		write_reg(pes_pkg::REG_FRAME, '0);
		write_reg(pes_pkg::REG_GRAVITY, {16'sd256, -16'sd256, 16'sd0});
		obj.pos = {32'sd7, -32'sd7, 32'sd0};
		obj.vel = {VAL_MIN, VAL_MAX, -16'sd1};
		obj.acc = {VAL_MAX, VAL_MIN, -16'sd1};
		send_body(obj);
		wait_idle();
		write_reg(pes_pkg::REG_KEEP, {16'h0001, 16'h0001, 16'h0001});
		write_reg(pes_pkg::REG_FRAME, 48'h0000_0000_0001);
		send_body(obj);
		wait_idle();
	endtask

	// Paused: every field passes through untouched, whatever the other registers say.
	task automatic test_pause();
		body_t obj;
		write_reg(pes_pkg::REG_PAUSED, 48'h1);
		obj.pos = {pes_pkg::POS_MAX, pes_pkg::POS_MIN, 32'sd0};
		obj.vel = {VAL_MAX, VAL_MIN, 16'sd0};
		obj.acc = {VAL_MIN, 16'sd0, VAL_MAX};
		send_body(obj);
		send_body(rand_body());
		send_body(rand_body());
		wait_idle();
		write_reg(pes_pkg::REG_PAUSED, 48'h0);
	endtask

	// Writes to indexes past the last register must change nothing.
	task automatic test_ignored_indexes();
		for (int i = int'(pes_pkg::REG_PAUSED) + 1; i < 2**pes_pkg::CFG_IDX_W; i++)
			write_reg(pes_pkg::cfg_idx_t'(i), '1);
		send_body(rand_body());
		send_body(rand_body());
		wait_idle();
	endtask

	// Random objects under random settings, through each idling pattern.
	task automatic test_random_traffic();
		int send_pct [4] = '{0, 84, 0, 38};
		int recv_pct [4] = '{0, 0, 84, 38};
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct  = send_pct[ph];
			recv_stall_pct = recv_pct[ph];
			for (int c = 0; c < 2; c++) begin
				wait_idle();
				rand_config();
				repeat (RANDOM_PER_CFG)
					send_body(rand_body());
			end
		end
		wait_idle();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
	endtask

	initial begin
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_values();
		test_velocity_clamp();
		test_zero_factors();
		test_pause();
		test_ignored_indexes();
		test_random_traffic();

		// let any stray result surface before the verdict
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/pes_pkg.sv
hw/rtl/particle_euler_step.sv
hw/rtl/pes_checker.sv
test/tb_particle_euler_step.sv
